// ===== rtl/core/utf8e_pkg.sv =====
// utf8e_pkg: shared types, constants and encoding helpers for the bounded UTF-8 encoder.
// No dependencies; used by every module under rtl/core.
`timescale 1ns / 1ps

package utf8e_pkg;

	// Field widths
	localparam int unsigned CP_W   = 21;
	localparam int unsigned CNT_W  = 16;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W  = 3;

	// Default depth of the front-to-back queue
	localparam int unsigned FIFO_DEPTH_DFLT = 2;

	// Configuration register map (word index) and reset value
	localparam int unsigned PADDR_W          = 3;
	localparam logic        REG_BUFFER_BYTES = 1'b0;
	localparam logic [CNT_W-1:0] BUF_BYTES_RST = 16'd256;

	// Code point range limits
	localparam logic [CP_W-1:0] MAX_1B = 21'h00007F;
	localparam logic [CP_W-1:0] MAX_2B = 21'h0007FF;
	localparam logic [CP_W-1:0] MAX_3B = 21'h00FFFF;
	localparam logic [CP_W-1:0] MAX_4B = 21'h10FFFF;

	// Lead and continuation byte marks
	localparam logic [BYTE_W-1:0] LEAD2 = 8'hC0;
	localparam logic [BYTE_W-1:0] LEAD3 = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD4 = 8'hF0;
	localparam logic [BYTE_W-1:0] CONT  = 8'h80;

	// Encoded length codes; LEN_NONE marks an out-of-range code point
	localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
	localparam logic [LEN_W-1:0] LEN_1    = 3'd1;
	localparam logic [LEN_W-1:0] LEN_2    = 3'd2;
	localparam logic [LEN_W-1:0] LEN_3    = 3'd3;
	localparam logic [LEN_W-1:0] LEN_4    = 3'd4;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            last_in;
	} utf8e_in_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              byte_valid;
		logic              is_terminator;
		logic [CNT_W-1:0]  total_bytes;
		logic              invalid_seen;
		logic              last_out;
	} utf8e_out_t;

	// One queued command: encoded bytes to send, then an optional end-of-string result
	typedef struct packed {
		logic [3:0][BYTE_W-1:0] enc;
		logic [LEN_W-1:0]       nbytes;
		logic                   has_tail;
		logic                   room;
		logic [CNT_W-1:0]       total;
		logic                   invalid;
	} utf8e_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} utf8e_q_stat_t;

	function automatic logic [LEN_W-1:0] enc_len(input logic [CP_W-1:0] cp);
		logic [LEN_W-1:0] len;
		if (cp <= MAX_1B) begin
			len = LEN_1;
		end else if (cp <= MAX_2B) begin
			len = LEN_2;
		end else if (cp <= MAX_3B) begin
			len = LEN_3;
		end else if (cp <= MAX_4B) begin
			len = LEN_4;
		end else begin
			len = LEN_NONE;
		end
		return len;
	endfunction

	// Byte 0 is sent first
	function automatic logic [3:0][BYTE_W-1:0] enc_bytes(input logic [CP_W-1:0] cp,
			input logic [LEN_W-1:0] len);
		logic [3:0][BYTE_W-1:0] b;
		b = '0;
		case (len)
			LEN_1: begin
				b[0] = cp[7:0];
			end
			LEN_2: begin
				b[0] = LEAD2 | {3'b000, cp[10:6]};
				b[1] = CONT | {2'b00, cp[5:0]};
			end
			LEN_3: begin
				b[0] = LEAD3 | {4'b0000, cp[15:12]};
				b[1] = CONT | {2'b00, cp[11:6]};
				b[2] = CONT | {2'b00, cp[5:0]};
			end
			LEN_4: begin
				b[0] = LEAD4 | {5'b00000, cp[20:18]};
				b[1] = CONT | {2'b00, cp[17:12]};
				b[2] = CONT | {2'b00, cp[11:6]};
				b[3] = CONT | {2'b00, cp[5:0]};
			end
			default: begin
				b = '0;
			end
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/core/utf8e_front.sv =====
// utf8e_front: accepts code points, checks capacity and range, keeps per-string state.
// Depends on utf8e_pkg; feeds utf8e_fifo.
`timescale 1ns / 1ps

module utf8e_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  utf8e_pkg::utf8e_in_t                in_data,
	input  logic [utf8e_pkg::CNT_W-1:0]         buffer_bytes,
	input  utf8e_pkg::utf8e_q_stat_t            q_stat,
	output logic                                push,
	output utf8e_pkg::utf8e_cmd_t               cmd
);

	logic [utf8e_pkg::CNT_W-1:0] used_q, used_nxt;
	logic                        stopped_q, err_q;
	logic                        stop_nxt, err_nxt;
	logic [utf8e_pkg::LEN_W-1:0] len;
	logic [utf8e_pkg::CNT_W:0]   sum;
	logic                        fits, emit, accept;

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;

	// Classify the code point and run the fit test
	always_comb begin
		len      = utf8e_pkg::enc_len(in_data.code_point);
		sum      = {1'b0, used_q} + {{(utf8e_pkg::CNT_W + 1 - utf8e_pkg::LEN_W){1'b0}}, len};
		fits     = sum <= {1'b0, buffer_bytes};
		emit     = 1'b0;
		used_nxt = used_q;
		stop_nxt = stopped_q;
		err_nxt  = err_q;
		if (!stopped_q) begin
			if (len == utf8e_pkg::LEN_NONE) begin
				stop_nxt = 1'b1;
				err_nxt  = 1'b1;
			end else if (!fits) begin
				stop_nxt = 1'b1;
			end else begin
				emit     = 1'b1;
				used_nxt = sum[utf8e_pkg::CNT_W-1:0];
			end
		end
	end

	// Command for the back end
	always_comb begin
		cmd.enc      = utf8e_pkg::enc_bytes(in_data.code_point, len);
		cmd.nbytes   = emit ? len : utf8e_pkg::LEN_NONE;
		cmd.has_tail = in_data.last_in;
		cmd.room     = used_nxt < buffer_bytes;
		cmd.total    = used_nxt;
		cmd.invalid  = err_nxt;
	end

	// Nothing to send for a dropped character that does not end the string
	assign push = accept && (emit || in_data.last_in);

	// Per-string state; cleared at the end of each string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			stopped_q <= 1'b0;
			err_q     <= 1'b0;
		end else if (accept) begin
			if (in_data.last_in) begin
				used_q    <= '0;
				stopped_q <= 1'b0;
				err_q     <= 1'b0;
			end else begin
				used_q    <= used_nxt;
				stopped_q <= stop_nxt;
				err_q     <= err_nxt;
			end
		end
	end

endmodule

// ===== rtl/core/utf8e_fifo.sv =====
// utf8e_fifo: short register queue of commands between front and back.
// Depends on utf8e_pkg.
`timescale 1ns / 1ps

module utf8e_fifo #(
	parameter int unsigned DEPTH = utf8e_pkg::FIFO_DEPTH_DFLT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  utf8e_pkg::utf8e_cmd_t    wr_cmd,
	input  logic                     pop,
	output utf8e_pkg::utf8e_cmd_t    head,
	output utf8e_pkg::utf8e_q_stat_t stat
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	utf8e_pkg::utf8e_cmd_t mem_q [DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]      cnt_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = cnt_q == CNT_FULL;
	assign stat.empty = cnt_q == '0;

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/utf8e_back.sv =====
// utf8e_back: walks each queued command, one result per cycle while out_ready allows, into the output register.
// Depends on utf8e_pkg; fed by utf8e_fifo.
`timescale 1ns / 1ps

module utf8e_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  utf8e_pkg::utf8e_cmd_t    head,
	input  utf8e_pkg::utf8e_q_stat_t q_stat,
	output logic                     pop,
	output logic                     out_valid,
	input  logic                     out_ready,
	output utf8e_pkg::utf8e_out_t    out_data
);

	logic [utf8e_pkg::LEN_W-1:0] pos_q;
	logic                        out_valid_q;
	utf8e_pkg::utf8e_out_t       out_q, res;
	logic                        load, fire, at_tail, done;

	assign load    = !out_valid_q || out_ready;
	assign fire    = load && !q_stat.empty;
	assign at_tail = pos_q == head.nbytes;
	assign done    = at_tail || ((pos_q + 1'b1) == head.nbytes && !head.has_tail);
	assign pop     = fire && done;

	// Select the next result: an encoded byte, or the end-of-string result
	always_comb begin
		res = '0;
		if (at_tail) begin
			res.byte_valid    = head.room;
			res.is_terminator = head.room;
			res.total_bytes   = head.total;
			res.invalid_seen  = head.invalid;
			res.last_out      = 1'b1;
		end else begin
			res.out_byte   = head.enc[pos_q[1:0]];
			res.byte_valid = 1'b1;
		end
	end

	// Position within the current command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= !q_stat.empty;
			end
			if (fire) begin
				pos_q <= done ? '0 : pos_q + 1'b1;
			end
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== rtl/core/utf8_encoder_bounded_top.sv =====
// utf8_encoder_bounded_top: bounded UTF-8 string encoder, top level.
// Depends on utf8e_pkg, utf8e_front, utf8e_fifo and utf8e_back.
//
//   Channel   Direction  Handshake           Transaction carries
//   in        sink       in_valid/in_ready   code_point, last_in
//   out       source     out_valid/out_ready out_byte, byte_valid, is_terminator,
//                                            total_bytes, invalid_seen, last_out
//   apb       slave      psel/penable/pready buffer_bytes at word 0
//
// Results leave one per cycle, while out_ready allows, from a single output register; an item
// gives its encoded bytes (0 to 4) plus one more result when it ends a string.
// The front end takes an item per cycle while the queue (FIFO_DEPTH entries) has space;
// the output stage sets the sustained item rate.
// Reset (arst_n low) clears string state, the queue and the output valid flag, and sets
// buffer_bytes to 256. Output stalls back up through the queue to in_ready.
`timescale 1ns / 1ps

module utf8_encoder_bounded_top #(
	parameter int unsigned FIFO_DEPTH = utf8e_pkg::FIFO_DEPTH_DFLT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  utf8e_pkg::utf8e_in_t              in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output utf8e_pkg::utf8e_out_t             out_data,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [utf8e_pkg::PADDR_W-1:0]     paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	logic [utf8e_pkg::CNT_W-1:0] buf_bytes_q;
	logic                        cfg_wr, sel_buf;
	logic                        push, pop;
	utf8e_pkg::utf8e_cmd_t       cmd, head;
	utf8e_pkg::utf8e_q_stat_t    q_stat;

	// Configuration register
	assign pready  = 1'b1;
	assign sel_buf = paddr[utf8e_pkg::PADDR_W-1:2] == utf8e_pkg::REG_BUFFER_BYTES;
	assign cfg_wr  = psel && penable && pwrite && pready && sel_buf;
	assign prdata  = sel_buf ? {16'h0000, buf_bytes_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_bytes_q <= utf8e_pkg::BUF_BYTES_RST;
		end else if (cfg_wr) begin
			buf_bytes_q <= pwdata[utf8e_pkg::CNT_W-1:0];
		end
	end

	utf8e_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.buffer_bytes (buf_bytes_q),
		.q_stat       (q_stat),
		.push         (push),
		.cmd          (cmd)
	);

	utf8e_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (cmd),
		.pop    (pop),
		.head   (head),
		.stat   (q_stat)
	);

	utf8e_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// The queue is never written while full nor read while empty
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_stat.full && !pop))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && q_stat.empty))
		else $error("queue read while empty");

	// A result only appears after a command was waiting
	a_out_from_queue: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!q_stat.empty))
		else $error("result without queued command");

	// Byte results are always stored; the end result stores only the nul
	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.last_out ? (out_data.byte_valid == out_data.is_terminator)
			: (out_data.byte_valid && !out_data.is_terminator)))
		else $error("inconsistent result flags");

endmodule
